[src/cva_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cva_pkg;

    localparam int IN_WIDTH_DEF   = 24;
    localparam int LAST_SHIFT_DEF = 16;
    localparam int GUARD_W        = 4;
    localparam int ANGLE_W        = 20;
    localparam int M_TDATA_W      = ((ANGLE_W + 7) / 8) * 8;
    localparam int ATAN_IDX_W     = 5;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    localparam angle_t HALF_TURN  = 20'sd205886;
    localparam angle_t ANGLE_BOUND = 20'sd392692;

    function automatic angle_t atan_step(input logic [ATAN_IDX_W-1:0] idx);
        angle_t res;
        case (idx)
            5'd0:    res = 20'sd72558;
            5'd1:    res = 20'sd51472;
            5'd2:    res = 20'sd30386;
            5'd3:    res = 20'sd16055;
            5'd4:    res = 20'sd8150;
            5'd5:    res = 20'sd4091;
            5'd6:    res = 20'sd2047;
            5'd7:    res = 20'sd1024;
            5'd8:    res = 20'sd512;
            5'd9:    res = 20'sd256;
            5'd10:   res = 20'sd128;
            5'd11:   res = 20'sd64;
            5'd12:   res = 20'sd32;
            5'd13:   res = 20'sd16;
            5'd14:   res = 20'sd8;
            5'd15:   res = 20'sd4;
            5'd16:   res = 20'sd2;
            5'd17:   res = 20'sd1;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[src/cordic_vector_angle_top.sv]
// An input transfer passes through one register stage for the half-turn fold, one for the
// tan = 2 rotation and one per shift-add rotation before its result reaches the output.
// Throughput is one vector per cycle unless the output stalls; each rotation stage holds one
// add or subtract per value; a stalled stage takes a new item once its successor frees up.
// Reset is synchronous and active low; it clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module cordic_vector_angle_top
    import cva_pkg::*;
#(
    parameter int IN_WIDTH   = IN_WIDTH_DEF,
    parameter int LAST_SHIFT = LAST_SHIFT_DEF,
    localparam int S_TDATA_W = ((2 * IN_WIDTH + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0 up: vec_x, vec_y, zero fill.
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // Fields from bit 0 up: angle, zero fill.
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int W    = IN_WIDTH + GUARD_W;
    localparam int NSTG = LAST_SHIFT + 3;

    typedef logic signed [W-1:0] coord_t;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stage_ready;
    coord_t          x_reg  [0:NSTG-1];
    coord_t          y_reg  [0:NSTG-1];
    angle_t          th_reg [0:NSTG-1];
    coord_t          x_next [0:NSTG-1];
    coord_t          y_next [0:NSTG-1];
    angle_t          th_next [0:NSTG-1];
    logic [NSTG-1:0] valid_next;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stage
            if (k == NSTG - 1) begin : g_rdy_last
                assign stage_ready[k] = !valid_reg[k] || m_axis_tready;
            end else begin : g_rdy_mid
                assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
            end

            if (k == 0) begin : g_fold
                logic signed [IN_WIDTH-1:0] in_x;
                logic signed [IN_WIDTH-1:0] in_y;
                coord_t                     ext_x;
                coord_t                     ext_y;
                coord_t                     fold_y;
                angle_t                     start_th;
                assign in_x       = s_axis_tdata[IN_WIDTH-1:0];
                assign in_y       = s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];
                assign ext_x      = {{GUARD_W{in_x[IN_WIDTH-1]}}, in_x};
                assign ext_y      = {{GUARD_W{in_y[IN_WIDTH-1]}}, in_y};
                assign valid_next[k] = s_axis_tvalid;
                always_comb begin
                    if (ext_x < 0) begin
                        x_next[k] = -ext_x;
                        fold_y    = -ext_y;
                        start_th  = HALF_TURN;
                    end else begin
                        x_next[k] = ext_x;
                        fold_y    = ext_y;
                        start_th  = '0;
                    end
                    y_next[k] = fold_y;
                    if (fold_y > 0) begin
                        th_next[k] = -start_th;
                    end else begin
                        th_next[k] = start_th;
                    end
                end
            end else begin : g_rot
                localparam int SH = (k == 1) ? 0 : k - 2;
                coord_t dx;
                coord_t dy;
                angle_t da;
                assign valid_next[k] = valid_reg[k-1];
                assign da = atan_step(ATAN_IDX_W'(k - 1));
                always_comb begin
                    if (k == 1) begin
                        dx = x_reg[k-1] <<< 1;
                        dy = y_reg[k-1] <<< 1;
                    end else begin
                        dx = x_reg[k-1] >>> SH;
                        dy = y_reg[k-1] >>> SH;
                    end
                    if (y_reg[k-1] < 0) begin
                        y_next[k]  = y_reg[k-1] + dx;
                        x_next[k]  = x_reg[k-1] - dy;
                        th_next[k] = th_reg[k-1] - da;
                    end else begin
                        y_next[k]  = y_reg[k-1] - dx;
                        x_next[k]  = x_reg[k-1] + dy;
                        th_next[k] = th_reg[k-1] + da;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (stage_ready[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (stage_ready[k] && valid_next[k]) begin
                    x_reg[k]  <= x_next[k];
                    y_reg[k]  <= y_next[k];
                    th_reg[k] <= th_next[k];
                end
            end
        end
    endgenerate

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[NSTG-1];
    assign m_axis_tdata  = {{(M_TDATA_W - ANGLE_W){1'b0}}, th_reg[NSTG-1]};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg == '0))
        else $error("pipeline holds an item after reset");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (th_reg[NSTG-1] <= ANGLE_BOUND && th_reg[NSTG-1] >= -ANGLE_BOUND))
        else $error("angle outside the reachable range");

    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[1] && !stage_ready[1]) |=> (valid_reg[1] && $stable(th_reg[1])))
        else $error("stalled stage lost or changed its item");

endmodule

`default_nettype wire
